// ===== rtl/core/pid_loop_with_drive_accumulator_defines.svh =====
// Assertion macros for the PID loop with drive accumulator
`ifndef PID_LOOP_WITH_DRIVE_ACCUMULATOR_DEFINES_SVH
`define PID_LOOP_WITH_DRIVE_ACCUMULATOR_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define PLDA_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define PLDA_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/core/pldacc_pkg.sv =====
// Package: constants, register indexes and sequencer states of the PID loop
package pldacc_pkg;
	localparam int FRAC_BITS_DEF  = 16;
	localparam int DATA_WIDTH_DEF = 32;
	localparam int CFG_IDX_W      = 3;

	localparam logic [CFG_IDX_W-1:0] REG_PROP_GAIN  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_INTEG_GAIN = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_DERIV_GAIN = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_OUT_LOW    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_OUT_HIGH   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_BOOST      = 3'd5;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MUL_ES,
		ST_DIV,
		ST_MUL_P,
		ST_MUL_I,
		ST_MUL_D,
		ST_CLAMP,
		ST_MUL_B,
		ST_DRIVE
	} st_t;
endpackage

// ===== rtl/core/pldacc_if.sv =====
// Channel interfaces: input word, result word and configuration writes
interface pldacc_cmd_if import pldacc_pkg::*; #(
	parameter int DATA_WIDTH = DATA_WIDTH_DEF
);
	logic                         valid;
	logic                         ready;
	logic signed [DATA_WIDTH-1:0] target_value;
	logic signed [DATA_WIDTH-1:0] measured_value;
	logic        [DATA_WIDTH-2:0] time_step;

	modport source (output valid, target_value, measured_value, time_step, input ready);
	modport sink (input valid, target_value, measured_value, time_step, output ready);
endinterface

interface pldacc_rsp_if import pldacc_pkg::*; #(
	parameter int DATA_WIDTH = DATA_WIDTH_DEF
);
	logic                         valid;
	logic                         ready;
	logic signed [DATA_WIDTH-1:0] pid_output;
	logic signed [DATA_WIDTH-1:0] drive_total;
	logic                         drive_negative;
	logic                         step_zero;

	modport source (output valid, pid_output, drive_total, drive_negative, step_zero,
		input ready);
	modport sink (input valid, pid_output, drive_total, drive_negative, step_zero,
		output ready);
endinterface

interface pldacc_cfg_if import pldacc_pkg::*; #(
	parameter int DATA_WIDTH = DATA_WIDTH_DEF
);
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [DATA_WIDTH-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/core/pid_loop_with_drive_accumulator.sv =====
// PID controller with output clamp and saturating drive accumulator, bit-serial
// Usage:
//  cmd: one word per control update (target, measured value, time step, Q format
//   with FRAC_BITS fraction bits). Taken only while the sequencer is idle.
//  rsp: one word per update: clamped PID output, drive total, negative flag and
//   zero-step flag. Held in an output register until taken.
//  cfg: register writes (index, data), always ready; write only while idle.
// Datapath: five products go through one shift-add multiplier, one bit per
//  cycle; the derivative quotient through a restoring divider, one bit per
//  cycle. The divider is skipped when the time step is zero.
// Updates: one at a time; the next word is taken while the last result still
//  waits in the output register.
// Stall: if rsp is not taken, the sequencer holds in its final step until the
//  output register frees.
// Reset: gains, limits and boost to their defaults, integral, last error and
//  drive accumulator to zero, output register empty.
`include "pid_loop_with_drive_accumulator_defines.svh"

module pid_loop_with_drive_accumulator import pldacc_pkg::*; #(
	parameter int FRAC_BITS  = FRAC_BITS_DEF,
	parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	pldacc_cmd_if.sink   cmd,
	pldacc_rsp_if.source rsp,
	pldacc_cfg_if.sink   cfg
);
	localparam int W   = DATA_WIDTH;
	localparam int F   = FRAC_BITS;
	localparam int WW  = W + F;
	localparam int PW  = 2 * WW;
	localparam int QW  = PW - F;
	localparam int NW  = W + F + 2;
	localparam int SW  = W - 1;
	localparam int SMW = WW + 2;
	localparam int CW  = $clog2(((WW > NW) ? WW : NW) + 2);

	st_t st_q, st_d;
	logic [CW-1:0] cnt_q;

	logic signed [W-1:0] kp_q, ki_q, kd_q, lo_q, hi_q, boost_q;

	logic signed [W:0]     err_q, prev_q;
	logic [SW-1:0]         step_q;
	logic                  zero_q;
	logic signed [WW-1:0]  integ_q, rate_q;
	logic signed [SMW-1:0] sum_q;
	logic signed [W-1:0]   pid_q, acc_q;

	logic [PW-1:0] mp_q;
	logic [WW-1:0] ma_q;
	logic          mneg_q;
	logic [NW-1:0] dq_q;
	logic [SW-1:0] dr_q;
	logic          dneg_q;

	logic                ov_q, o_neg_q, o_zero_q;
	logic signed [W-1:0] o_pid_q, o_drive_q;

	logic mul_done, div_done, out_free, cmd_rdy;

	logic signed [WW-1:0] opa, opb, mres;
	logic [WW-1:0]        absa, absb, addend;
	logic [WW:0]          hi_sum;
	logic [QW-1:0]        mq;
	logic [QW:0]          mv;
	logic signed [W:0]    err_in;
	logic signed [W+1:0]  diff;
	logic [W+1:0]         absd;
	logic [SW:0]          rsh;
	logic                 qbit;
	logic signed [WW-1:0] rate_sat;
	logic [WW:0]          isum, dsum;
	logic signed [SMW-1:0] lo_e, hi_e, mres_e;

	// control outputs
	always_comb begin
		cmd_rdy  = (st_q == ST_IDLE);
		mul_done = (cnt_q == CW'(WW + 1));
		div_done = (cnt_q == CW'(NW));
		out_free = !ov_q || rsp.ready;
	end

	assign cmd.ready          = cmd_rdy;
	assign cfg.ready          = 1'b1;
	assign rsp.valid          = ov_q;
	assign rsp.pid_output     = o_pid_q;
	assign rsp.drive_total    = o_drive_q;
	assign rsp.drive_negative = o_neg_q;
	assign rsp.step_zero      = o_zero_q;

	always_comb begin
		st_d = st_q;
		unique case (st_q)
			ST_IDLE:   if (cmd.valid) st_d = ST_MUL_ES;
			ST_MUL_ES: if (mul_done) st_d = zero_q ? ST_MUL_P : ST_DIV;
			ST_DIV:    if (div_done) st_d = ST_MUL_P;
			ST_MUL_P:  if (mul_done) st_d = ST_MUL_I;
			ST_MUL_I:  if (mul_done) st_d = ST_MUL_D;
			ST_MUL_D:  if (mul_done) st_d = ST_CLAMP;
			ST_CLAMP:  st_d = ST_MUL_B;
			ST_MUL_B:  if (mul_done) st_d = ST_DRIVE;
			ST_DRIVE:  if (out_free) st_d = ST_IDLE;
			default:   st_d = ST_IDLE;
		endcase
	end

	// multiplier operands
	always_comb begin
		opa = '0;
		opb = '0;
		unique case (st_q)
			ST_MUL_ES: begin
				opa = {{(WW-W-1){err_q[W]}}, err_q};
				opb = {{(WW-SW){1'b0}}, step_q};
			end
			ST_MUL_P: begin
				opa = {{(WW-W){kp_q[W-1]}}, kp_q};
				opb = {{(WW-W-1){err_q[W]}}, err_q};
			end
			ST_MUL_I: begin
				opa = {{(WW-W){ki_q[W-1]}}, ki_q};
				opb = integ_q;
			end
			ST_MUL_D: begin
				opa = {{(WW-W){kd_q[W-1]}}, kd_q};
				opb = rate_q;
			end
			ST_MUL_B: begin
				opa = {{(WW-W){pid_q[W-1]}}, pid_q};
				opb = {{(WW-W){boost_q[W-1]}}, boost_q};
			end
			default: begin
				opa = '0;
				opb = '0;
			end
		endcase
		absa   = opa[WW-1] ? (~opa + 1'b1) : opa;
		absb   = opb[WW-1] ? (~opb + 1'b1) : opb;
		addend = mp_q[0] ? ma_q : '0;
		hi_sum = {1'b0, mp_q[PW-1:WW]} + {1'b0, addend};
	end

	// floor(product / 2^F), saturated to WW bits
	always_comb begin
		mq   = mp_q[PW-1:F];
		mv   = {1'b0, mq} + {{QW{1'b0}}, |mp_q[F-1:0]};
		mres = '0;
		if (!mneg_q) begin
			if (mq > {{(QW-WW+1){1'b0}}, {(WW-1){1'b1}}})
				mres = {1'b0, {(WW-1){1'b1}}};
			else
				mres = mq[WW-1:0];
		end else begin
			if (mv >= ((QW+1)'(1) << (WW-1)))
				mres = {1'b1, {(WW-1){1'b0}}};
			else
				mres = ~mv[WW-1:0] + 1'b1;
		end
	end

	// entry arithmetic, divider step, saturations
	always_comb begin
		err_in = {cmd.target_value[W-1], cmd.target_value}
			- {cmd.measured_value[W-1], cmd.measured_value};
		diff   = {err_in[W], err_in} - {prev_q[W], prev_q};
		absd   = diff[W+1] ? (~diff + 1'b1) : diff;
		rsh    = {dr_q, dq_q[NW-1]};
		qbit   = (rsh >= {1'b0, step_q});
		if (!dneg_q) begin
			if (dq_q > {{(NW-WW+1){1'b0}}, {(WW-1){1'b1}}})
				rate_sat = {1'b0, {(WW-1){1'b1}}};
			else
				rate_sat = dq_q[WW-1:0];
		end else begin
			if (dq_q > (NW'(1) << (WW-1)))
				rate_sat = {1'b1, {(WW-1){1'b0}}};
			else
				rate_sat = ~dq_q[WW-1:0] + 1'b1;
		end
		isum   = {integ_q[WW-1], integ_q} + {mres[WW-1], mres};
		dsum   = {{(WW-W+1){acc_q[W-1]}}, acc_q} + {mres[WW-1], mres};
		lo_e   = {{(SMW-W){lo_q[W-1]}}, lo_q};
		hi_e   = {{(SMW-W){hi_q[W-1]}}, hi_q};
		mres_e = {{(SMW-WW){mres[WW-1]}}, mres};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q    <= ST_IDLE;
			cnt_q   <= '0;
			kp_q    <= W'(1) << F;
			ki_q    <= '0;
			kd_q    <= '0;
			lo_q    <= {1'b1, {(W-1){1'b0}}};
			hi_q    <= {1'b0, {(W-1){1'b1}}};
			boost_q <= W'(1) << F;
			integ_q <= '0;
			prev_q  <= '0;
			acc_q   <= '0;
			ov_q    <= 1'b0;
		end else begin
			st_q <= st_d;
			if (st_d != st_q)
				cnt_q <= '0;
			else if (st_q != ST_IDLE && st_q != ST_CLAMP && st_q != ST_DRIVE)
				cnt_q <= cnt_q + 1'b1;

			if (cfg.valid) begin
				case (cfg.index)
					REG_PROP_GAIN:  kp_q    <= cfg.data;
					REG_INTEG_GAIN: ki_q    <= cfg.data;
					REG_DERIV_GAIN: kd_q    <= cfg.data;
					REG_OUT_LOW:    lo_q    <= cfg.data;
					REG_OUT_HIGH:   hi_q    <= cfg.data;
					REG_BOOST:      boost_q <= cfg.data;
					default:        ;
				endcase
			end

			if (st_q == ST_DRIVE && out_free)
				ov_q <= 1'b1;
			else if (rsp.ready)
				ov_q <= 1'b0;

			unique case (st_q)
				ST_IDLE: if (cmd.valid) prev_q <= err_in;
				ST_MUL_ES: if (mul_done) begin
					if (isum[WW] != isum[WW-1])
						integ_q <= isum[WW] ? {1'b1, {(WW-1){1'b0}}}
							: {1'b0, {(WW-1){1'b1}}};
					else
						integ_q <= isum[WW-1:0];
				end
				ST_MUL_B: if (mul_done) begin
					if (!(&dsum[WW:W-1] || ~|dsum[WW:W-1]))
						acc_q <= dsum[WW] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
					else
						acc_q <= dsum[W-1:0];
				end
				default: ;
			endcase
		end
	end

	// datapath, no reset
	always_ff @(posedge clk) begin
		unique case (st_q)
			ST_IDLE: if (cmd.valid) begin
				err_q  <= err_in;
				step_q <= cmd.time_step;
				zero_q <= (cmd.time_step == '0);
				rate_q <= '0;
				dq_q   <= {absd, {F{1'b0}}};
				dr_q   <= '0;
				dneg_q <= diff[W+1];
			end
			ST_DIV: begin
				if (div_done)
					rate_q <= rate_sat;
				else begin
					dr_q <= qbit ? SW'(rsh - {1'b0, step_q}) : rsh[SW-1:0];
					dq_q <= {dq_q[NW-2:0], qbit};
				end
			end
			ST_CLAMP: begin
				if (sum_q < lo_e)
					pid_q <= lo_q;
				else if (sum_q < hi_e)
					pid_q <= sum_q[W-1:0];
				else
					pid_q <= hi_q;
			end
			ST_DRIVE: if (out_free) begin
				o_pid_q   <= pid_q;
				o_drive_q <= acc_q;
				o_neg_q   <= acc_q[W-1];
				o_zero_q  <= zero_q;
			end
			default: ;
		endcase

		if (st_q == ST_MUL_ES || st_q == ST_MUL_P || st_q == ST_MUL_I
			|| st_q == ST_MUL_D || st_q == ST_MUL_B) begin
			if (cnt_q == '0) begin
				ma_q   <= absa;
				mp_q   <= {{WW{1'b0}}, absb};
				mneg_q <= opa[WW-1] ^ opb[WW-1];
			end else if (!mul_done)
				mp_q <= {hi_sum, mp_q[WW-1:1]};
			else if (st_q == ST_MUL_P)
				sum_q <= mres_e;
			else if (st_q == ST_MUL_I || st_q == ST_MUL_D)
				sum_q <= sum_q + mres_e;
		end
	end

	`PLDA_ASSERT_NXT(a_accept_starts, cmd.valid && cmd.ready, st_q == ST_MUL_ES, "accept did not start update")
	`PLDA_ASSERT_IMP(a_rsp_from_drive, $rose(ov_q), $past(st_q) == ST_DRIVE, "result word out of sequence")
	`PLDA_ASSERT_IMP(a_neg_flag, rsp.valid, rsp.drive_negative == rsp.drive_total[W-1], "negative flag mismatch")
	`PLDA_ASSERT_IMP(a_zero_no_div, st_q == ST_DIV, !zero_q, "divider run on zero step")
endmodule
